// ===== design/gsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gsr_pkg;

  localparam int unsigned ReportBytesDef = 18;
  localparam int unsigned MapEntriesDef  = 6;

  // Event codes.
  localparam logic [2:0] FUNC_FRAME_START = 3'd0;
  localparam logic [2:0] FUNC_FRAME_END   = 3'd1;
  localparam logic [2:0] FUNC_COMMAND     = 3'd2;
  localparam logic [2:0] FUNC_REPORT      = 3'd3;
  localparam logic [2:0] FUNC_TICK        = 3'd4;

  // Mode identifiers.
  localparam logic [7:0] MODE_DIGITAL  = 8'h41;
  localparam logic [7:0] MODE_ANALOG   = 8'h73;
  localparam logic [7:0] MODE_PRESSURE = 8'h79;
  localparam logic [7:0] MODE_ESCAPE   = 8'hF3;

  // Command codes.
  localparam logic [7:0] CMD_PRESSURE_CFG = 8'h40;
  localparam logic [7:0] CMD_POLL_QUERY   = 8'h41;
  localparam logic [7:0] CMD_POLL         = 8'h42;
  localparam logic [7:0] CMD_ESCAPE       = 8'h43;
  localparam logic [7:0] CMD_SET_MODE     = 8'h44;
  localparam logic [7:0] CMD_DEVICE_INFO  = 8'h45;
  localparam logic [7:0] CMD_CONST_A      = 8'h46;
  localparam logic [7:0] CMD_CONST_B      = 8'h47;
  localparam logic [7:0] CMD_CONST_C      = 8'h4C;
  localparam logic [7:0] CMD_ACT_MAP      = 8'h4D;
  localparam logic [7:0] CMD_POLL_CFG     = 8'h4F;

  localparam logic [7:0] ADDR_BYTE   = 8'h01;
  localparam logic [7:0] START_BYTE  = 8'hFF;
  localparam logic [7:0] HEADER_BYTE = 8'h5A;

  // Configuration register indexes.
  localparam logic [7:0] CFG_TIMEOUT  = 8'd0;
  localparam logic [7:0] CFG_STRENGTH = 8'd1;
  localparam logic [7:0] CFG_PMASK    = 8'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_RESP   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    TAB_PRESSURE_CFG,
    TAB_IDENTITY,
    TAB_C1A,
    TAB_C1B,
    TAB_C2,
    TAB_C3A,
    TAB_C3B,
    TAB_POLLCFG
  } tab_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] byte_value;
    logic [4:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       ack_request;
    logic [7:0] small_motor_drive;
    logic [7:0] large_motor_drive;
    logic [7:0] mode_id;
  } out_item_t;

  // Fixed six-entry response tables; reads past the end give zero.
  function automatic logic [7:0] tab_byte(tab_e sel, logic [4:0] idx);
    logic [47:0] row;
    logic [7:0]  val;
    unique case (sel)
      TAB_PRESSURE_CFG: row = 48'h00_00_02_00_00_5A;
      TAB_IDENTITY:     row = 48'h03_02_00_02_01_00;
      TAB_C1A:          row = 48'h00_00_01_02_00_0A;
      TAB_C1B:          row = 48'h00_00_01_01_01_14;
      TAB_C2:           row = 48'h00_00_02_00_01_00;
      TAB_C3A:          row = 48'h00_00_00_04_00_00;
      TAB_C3B:          row = 48'h00_00_00_07_00_10;
      default:          row = 48'h00_00_00_00_00_5A;
    endcase
    val = 8'h00;
    for (int i = 0; i < 6; i++) begin
      if (idx == 5'(i)) begin
        val = row[8*(5-i) +: 8];
      end
    end
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== design/gsr_report_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gsr_report_mem #(
  parameter int unsigned Depth = gsr_pkg::ReportBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       we_i,
  input  wire logic [4:0] waddr_i,
  input  wire logic [7:0] wdata_i,
  input  wire logic       re_i,
  input  wire logic [4:0] raddr_i,
  output logic      [7:0] rdata_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       rdata_q;
  logic             rok_q;
  logic             w_in, r_in;

  assign w_in = {1'b0, waddr_i} < 6'(Depth);
  assign r_in = {1'b0, raddr_i} < 6'(Depth);

  // Storage array with a registered read.
  always_ff @(posedge clk_i) begin
    if (we_i && w_in) begin
      mem_q[waddr_i[Aw-1:0]] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i[Aw-1:0]];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rok_q <= 1'b0;
    end else begin
      if (we_i && w_in) begin
        vld_q[waddr_i[Aw-1:0]] <= 1'b1;
      end
      if (re_i) begin
        rok_q <= r_in && vld_q[raddr_i[Aw-1:0]];
      end
    end
  end

  assign rdata_o = rok_q ? rdata_q : 8'h00;
endmodule
`default_nettype wire

// ===== design/gsr_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gsr_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire gsr_pkg::in_item_t  item_i,
  input  wire logic [7:0]         rpt_i,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_wdata_i,
  output gsr_pkg::out_item_t      res_o,
  output logic [4:0]              bc_next_o
);
  gsr_pkg::phase_e phase_q, phase_d;
  logic [4:0]  bc_q, bc_d;
  logic [7:0]  cmd_q, cmd_d, mode_q, mode_d, cs_q, cs_d, cs_use;
  logic        esca_q, esca_d, escp_q, escp_d, acka_q, acka_d;
  logic [7:0]  amap_q [6];
  logic [7:0]  amap_d [6];
  logic [7:0]  pset_q [6];
  logic [7:0]  pset_d [6];
  logic [15:0] idle_q, idle_d, tmo_q;
  logic [7:0]  sm_q, sm_d, lm_q, lm_d, str_q;
  logic [31:0] pmask_q, mask;
  logic [7:0]  rx, tx, len;
  logic        txv, ack, in_map;
  logic [2:0]  mi;

  assign rx = item_i.byte_value;

  // Next state and result for one item.
  always_comb begin
    phase_d = phase_q; bc_d = bc_q; cmd_d = cmd_q; mode_d = mode_q; cs_d = cs_q;
    esca_d = esca_q; escp_d = escp_q; acka_d = acka_q; idle_d = idle_q;
    sm_d = sm_q; lm_d = lm_q;
    amap_d = amap_q; pset_d = pset_q;
    txv = 1'b0; tx = 8'h00; ack = 1'b0; len = 8'd2; mask = '0; cs_use = cs_q;
    in_map = (bc_q != 5'd0) && (bc_q <= 5'd6);
    mi = 3'(bc_q - 5'd1);
    if (en_i) begin
      unique case (item_i.func)
        gsr_pkg::FUNC_FRAME_START: begin
          txv = 1'b1; tx = gsr_pkg::START_BYTE;
          phase_d = gsr_pkg::PH_IDLE; esca_d = escp_q;
        end
        gsr_pkg::FUNC_FRAME_END: begin
          phase_d = gsr_pkg::PH_IDLE; idle_d = '0;
        end
        gsr_pkg::FUNC_COMMAND: begin
          if (phase_q == gsr_pkg::PH_HEADER) begin
            cmd_d = rx; txv = 1'b1; tx = gsr_pkg::HEADER_BYTE; phase_d = gsr_pkg::PH_RESP;
          end else if (phase_q == gsr_pkg::PH_RESP) begin
            if (esca_q || mode_q == gsr_pkg::MODE_ANALOG) len = 8'd6;
            else if (mode_q == gsr_pkg::MODE_PRESSURE) len = 8'd18;
            txv = 1'b1;
            unique case (cmd_q)
              gsr_pkg::CMD_ESCAPE: begin
                tx = esca_q ? 8'h00 : rpt_i;
                if (bc_q == 5'd1) begin
                  if (rx == 8'h00) escp_d = 1'b0;
                  else if (rx == 8'h01) escp_d = 1'b1;
                end
              end
              gsr_pkg::CMD_POLL: begin
                escp_d = 1'b0; tx = rpt_i;
                if (in_map) begin
                  if (amap_q[mi] == 8'h00) sm_d = (rx == 8'hFF) ? str_q : 8'h00;
                  if (amap_q[mi] == 8'h01) lm_d = rx;
                end
              end
              gsr_pkg::CMD_PRESSURE_CFG: tx = gsr_pkg::tab_byte(gsr_pkg::TAB_PRESSURE_CFG, bc_q);
              gsr_pkg::CMD_POLL_QUERY: begin
                if (bc_q == 5'd5) tx = 8'h5A;
                else if (mode_q == gsr_pkg::MODE_DIGITAL) tx = 8'h00;
                else if (bc_q < 5'd6) tx = pset_q[bc_q[2:0]];
              end
              gsr_pkg::CMD_SET_MODE: begin
                if (bc_q == 5'd1) begin
                  if (rx == 8'h01) mode_d = gsr_pkg::MODE_ANALOG;
                  else if (rx == 8'h00) mode_d = gsr_pkg::MODE_DIGITAL;
                end
              end
              gsr_pkg::CMD_DEVICE_INFO: begin
                if (bc_q == 5'd2) tx = (mode_q == gsr_pkg::MODE_DIGITAL) ? 8'h00 : 8'h01;
                else tx = gsr_pkg::tab_byte(gsr_pkg::TAB_IDENTITY, bc_q);
              end
              gsr_pkg::CMD_CONST_A, gsr_pkg::CMD_CONST_C: begin
                if (bc_q == 5'd1) cs_use = rx;
                cs_d = cs_use;
                if (cs_use == 8'd0)
                  tx = gsr_pkg::tab_byte((cmd_q == gsr_pkg::CMD_CONST_A) ?
                                         gsr_pkg::TAB_C1A : gsr_pkg::TAB_C3A, bc_q);
                else if (cs_use == 8'd1)
                  tx = gsr_pkg::tab_byte((cmd_q == gsr_pkg::CMD_CONST_A) ?
                                         gsr_pkg::TAB_C1B : gsr_pkg::TAB_C3B, bc_q);
              end
              gsr_pkg::CMD_CONST_B: tx = gsr_pkg::tab_byte(gsr_pkg::TAB_C2, bc_q);
              gsr_pkg::CMD_ACT_MAP: begin
                if (bc_q < 5'd6) tx = amap_q[bc_q[2:0]];
                if (in_map) amap_d[mi] = rx;
              end
              gsr_pkg::CMD_POLL_CFG: begin
                tx = gsr_pkg::tab_byte(gsr_pkg::TAB_POLLCFG, bc_q);
                if (in_map) pset_d[mi] = rx;
                if (bc_q == 5'd5) begin
                  mask = {pset_d[0], pset_d[1], 8'h00, pset_d[2][1:0], 6'b0};
                  if ((mask & pmask_q) != '0) mode_d = gsr_pkg::MODE_PRESSURE;
                end
              end
              default: tx = 8'h00;
            endcase
            if ({3'b0, bc_q} >= len) acka_d = 1'b0;
            if (bc_q != 5'd31) bc_d = bc_q + 5'd1;
          end else begin
            if (rx == gsr_pkg::ADDR_BYTE) begin
              acka_d = 1'b1; phase_d = gsr_pkg::PH_HEADER; bc_d = '0; cmd_d = '0;
              txv = 1'b1; tx = esca_q ? gsr_pkg::MODE_ESCAPE : mode_q;
            end else begin
              acka_d = 1'b0;
            end
          end
          ack = acka_d;
        end
        gsr_pkg::FUNC_TICK: begin
          if (idle_q != 16'hFFFF) idle_d = idle_q + 16'd1;
          if (idle_d > tmo_q && phase_q == gsr_pkg::PH_IDLE) mode_d = gsr_pkg::MODE_DIGITAL;
        end
        default: ;
      endcase
    end
  end

  assign bc_next_o = bc_d;
  assign res_o = '{tx_valid: txv, tx_byte: tx, ack_request: ack,
                   small_motor_drive: sm_d, large_motor_drive: lm_d, mode_id: mode_d};

  // State and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gsr_pkg::PH_IDLE; bc_q <= '0; cmd_q <= '0;
      mode_q <= gsr_pkg::MODE_DIGITAL; cs_q <= '0;
      esca_q <= 1'b0; escp_q <= 1'b0; acka_q <= 1'b0; idle_q <= '0;
      sm_q <= '0; lm_q <= '0;
      for (int i = 0; i < 6; i++) amap_q[i] <= 8'hFF;
      pset_q[0] <= 8'hFF; pset_q[1] <= 8'hFF; pset_q[2] <= 8'h03;
      pset_q[3] <= 8'h00; pset_q[4] <= 8'h00; pset_q[5] <= 8'h5A;
      tmo_q <= 16'd10000; str_q <= 8'hFF; pmask_q <= 32'hFFFF0000;
    end else begin
      phase_q <= phase_d; bc_q <= bc_d; cmd_q <= cmd_d; mode_q <= mode_d; cs_q <= cs_d;
      esca_q <= esca_d; escp_q <= escp_d; acka_q <= acka_d; idle_q <= idle_d;
      sm_q <= sm_d; lm_q <= lm_d; amap_q <= amap_d; pset_q <= pset_d;
      if (cfg_we_i) begin
        if (cfg_index_i == gsr_pkg::CFG_TIMEOUT) tmo_q <= cfg_wdata_i[15:0];
        if (cfg_index_i == gsr_pkg::CFG_STRENGTH) str_q <= cfg_wdata_i[7:0];
        if (cfg_index_i == gsr_pkg::CFG_PMASK) pmask_q <= cfg_wdata_i;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/gamepad_spi_responder.sv =====
`timescale 1ns / 1ps
// Pipeline: an item's result passes through the stage register (the report read is
// registered alongside it) and then the output register; a held output stalls both.
// Throughput: one item per cycle; one report read, one report write and one state update
// per cycle set this figure, and a held output item stalls the input.
// Reset: asynchronous, active low; control state returns to its idle values at once and
// report bytes read as zero until written; item registers and storage are not reset.
`default_nettype none
module gamepad_spi_responder #(
  parameter int unsigned ReportBytes = gsr_pkg::ReportBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire gsr_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output gsr_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_wdata_i
);
  logic               adv, acc, s1_valid_q, out_valid_q;
  gsr_pkg::in_item_t  s1_item_q;
  gsr_pkg::out_item_t res, out_item_q;
  logic [7:0]         rpt;
  logic [4:0]         bc_next;

  // Whole pipeline moves unless the output item is held.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  gsr_report_mem #(.Depth(ReportBytes)) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (acc && in_item_i.func == gsr_pkg::FUNC_REPORT),
    .waddr_i (in_item_i.slot_index),
    .wdata_i (in_item_i.byte_value),
    .re_i    (acc),
    .raddr_i (bc_next),
    .rdata_o (rpt)
  );

  gsr_engine u_eng (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv && s1_valid_q),
    .item_i      (s1_item_q),
    .rpt_i       (rpt),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res),
    .bc_next_o   (bc_next)
  );

  // Stage and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q  <= in_item_i;
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
endmodule
`default_nettype wire
